/* rtl/core/jse_pkg.sv */
// jse_pkg: widths, command codes and capacity of the jump search engine.
// Used by the channel interfaces, the root unit and the top level.
package jse_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
  localparam int LEN_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int DATA_W       = 32;
  localparam int STEP_W       = (LEN_W + 1) / 2;
  localparam int STEP_IDX_W   = $clog2(STEP_W);
  localparam int SQ_W         = 2 * STEP_W;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_ELEMENTS);

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [LEN_W-1:0]         len_t;
  typedef logic [STEP_W-1:0]        step_t;
  typedef logic signed [DATA_W-1:0] elem_t;

endpackage

/* rtl/core/jse_ifs.sv */
// jse_ifs: request and response channel interfaces (valid/ready).
// Depends on jse_pkg for field widths.
interface jse_req_if import jse_pkg::*;;
  logic  valid;
  logic  ready;
  logic  cmd;
  addr_t slot;
  elem_t item_value;

  modport source (output valid, cmd, slot, item_value, input ready);
  modport sink   (input valid, cmd, slot, item_value, output ready);
endinterface

interface jse_rsp_if import jse_pkg::*;;
  logic  valid;
  logic  ready;
  logic  found;
  addr_t position;

  modport source (output valid, found, position, input ready);
  modport sink   (input valid, found, position, output ready);
endinterface

/* rtl/core/jse_sqrt.sv */
// jse_sqrt: bit-serial integer floor square root, one result bit per cycle.
// Depends on jse_pkg for widths.
module jse_sqrt import jse_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  len_t  n,
  output logic  busy,
  output step_t root
);

  len_t                  n_q;
  logic [STEP_IDX_W-1:0] bitn;
  step_t                 trial;
  logic [SQ_W-1:0]       square;

  assign trial  = root | (step_t'(1) << bitn);
  assign square = SQ_W'(trial) * SQ_W'(trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      root <= '0;
      bitn <= '0;
      n_q  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      root <= '0;
      bitn <= STEP_IDX_W'(STEP_W - 1);
      n_q  <= n;
    end else if (busy) begin
      if (square <= SQ_W'(n_q)) begin
        root <= trial;
      end
      if (bitn == '0) begin
        busy <= 1'b0;
      end else begin
        bitn <= bitn - STEP_IDX_W'(1);
      end
    end
  end

endmodule

/* rtl/core/jump_search_engine.sv */
// jump_search_engine: jump search over a 1024 x 32 element memory.
// Depends on jse_pkg, jse_ifs and jse_sqrt.
//
//  channel | dir | handshake     | payload
//  req     | in  | valid/ready   | cmd, slot, item_value
//  rsp     | out | valid/ready   | found, position (one item per search)
//  cfg     | in  | cfg_we        | cfg_data = array_length
//
// A write command is stored when it is accepted. A search keeps req stalled
// through the jump probes and the scanned entries, served by the single memory
// read port (one read per cycle), over the whole array when a target below
// element 0 forces a full scan, plus any wait for rsp to free the result
// register. A length write keeps req stalled while the root unit works. Reset
// is synchronous; the element memory is not cleared. The result register lets a
// write be taken while a result waits on rsp.
module jump_search_engine import jse_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  jse_req_if.sink         req,
  jse_rsp_if.source       rsp,
  input  logic            cfg_we,
  input  logic [LEN_W-1:0] cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_JUMP = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  elem_t mem [MAX_ELEMENTS];
  elem_t mem_q;

  logic [1:0] state;
  len_t       len;
  len_t       len_sat;
  step_t      step;
  logic       sq_busy;
  len_t       nxt;
  addr_t      start;
  logic       rd_vld;
  addr_t      rd_idx;
  elem_t      target;
  logic       fnd;
  addr_t      pos;
  logic       res_vld;
  logic       res_found;
  addr_t      res_pos;
  logic       res_load;
  logic       active;
  logic       issue;
  logic       eq;
  logic       gt;
  logic       req_acc;

  assign len_sat = (cfg_data > MAX_LEN) ? MAX_LEN : cfg_data;

  jse_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cfg_we),
    .n     (len_sat),
    .busy  (sq_busy),
    .root  (step)
  );

  assign req.ready = (state == ST_IDLE) && !sq_busy;
  assign req_acc   = req.valid && req.ready;
  assign active    = (state == ST_JUMP) || (state == ST_SCAN);
  assign issue     = active && (nxt < len);
  assign eq        = (mem_q == target);
  assign gt        = (mem_q > target);
  assign res_load  = (state == ST_DONE) && (!res_vld || rsp.ready);

  assign rsp.valid    = res_vld;
  assign rsp.found    = res_found;
  assign rsp.position = res_pos;

  always_ff @(posedge clk) begin
    if (req_acc && (req.cmd == CMD_WRITE)) begin
      mem[req.slot] <= req.item_value;
    end
    if (issue) begin
      mem_q <= mem[nxt[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (cfg_we) begin
      len <= len_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rd_vld  <= 1'b0;
      res_vld <= 1'b0;
      nxt     <= '0;
      start   <= '0;
      fnd     <= 1'b0;
      pos     <= '0;
    end else begin
      if (res_load) begin
        res_vld <= 1'b1;
      end else if (rsp.ready) begin
        res_vld <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_acc && (req.cmd == CMD_SEARCH)) begin
            target <= req.item_value;
            nxt    <= '0;
            start  <= '0;
            rd_vld <= 1'b0;
            fnd    <= 1'b0;
            pos    <= '0;
            state  <= (len == '0) ? ST_DONE : ST_JUMP;
          end
        end
        ST_JUMP: begin
          if (rd_vld && eq) begin
            fnd    <= 1'b1;
            pos    <= rd_idx;
            rd_vld <= 1'b0;
            state  <= ST_DONE;
          end else if (rd_vld && gt) begin
            nxt    <= LEN_W'(start);
            rd_vld <= 1'b0;
            state  <= ST_SCAN;
          end else begin
            if (rd_vld) begin
              start <= rd_idx;
            end
            if (issue) begin
              rd_vld <= 1'b1;
              rd_idx <= nxt[ADDR_W-1:0];
              nxt    <= nxt + LEN_W'(step);
            end else if (!rd_vld) begin
              nxt   <= LEN_W'(start);
              state <= ST_SCAN;
            end else begin
              rd_vld <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          if (rd_vld && eq) begin
            fnd    <= 1'b1;
            pos    <= rd_idx;
            rd_vld <= 1'b0;
            state  <= ST_DONE;
          end else if (issue) begin
            rd_vld <= 1'b1;
            rd_idx <= nxt[ADDR_W-1:0];
            nxt    <= nxt + LEN_W'(1);
          end else if (!rd_vld) begin
            state <= ST_DONE;
          end else begin
            rd_vld <= 1'b0;
          end
        end
        ST_DONE: begin
          if (res_load) begin
            res_found <= fnd;
            res_pos   <= pos;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  logic [SQ_W-1:0] step_sq;
  logic [SQ_W-1:0] step1_sq;

  assign step_sq  = SQ_W'(step) * SQ_W'(step);
  assign step1_sq = (SQ_W'(step) + SQ_W'(1)) * (SQ_W'(step) + SQ_W'(1));

  a_root_ok: assert property (@(posedge clk) disable iff (rst)
    !sq_busy |-> (step_sq <= SQ_W'(len)) && (step1_sq > SQ_W'(len)))
    else $error("jump step is not the floor root of the length");

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (sq_busy || (state != ST_IDLE)) |-> !req.ready)
    else $error("request taken while busy");

  a_rd_in_search: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> active)
    else $error("read in flight outside a search");

  a_miss_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.found) |-> (rsp.position == '0))
    else $error("miss reported with a non-zero position");

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    res_load |=> (state == ST_IDLE) && res_vld)
    else $error("finished search did not reach the result register");

endmodule
